// ----- rtl/encoder_position_and_phase_unit_assert.svh -----
// Assertion macros, clocked on i_clk; EPP_ASSERT is checked outside reset, EPP_ASSERT_ALWAYS also in reset.
`ifndef ENCODER_POSITION_AND_PHASE_UNIT_ASSERT_SVH
`define ENCODER_POSITION_AND_PHASE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define EPP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("epp assertion failed");
`define EPP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("epp assertion failed");
`else
`define EPP_ASSERT(label, prop)
`define EPP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/epp_pkg.sv -----
package epp_pkg;

    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned RAW_W      = 14;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned POLE_W     = 7;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POLE_W-1:0] POLE_RESET = 7'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REVERSE = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_CENTER  = 2'd2,
        CFG_POLES   = 2'd3
    } t_cfg_addr;

endpackage

// ----- rtl/epp_interfaces.sv -----
interface epp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              read_ok;
    logic [epp_pkg::RAW_W-1:0]         raw_angle;
    logic [epp_pkg::CODE_W-1:0]        error_code;
    logic [epp_pkg::STAMP_W-1:0]       time_stamp;

    modport source (output valid, read_ok, raw_angle, error_code, time_stamp, input ready);
    modport sink   (input valid, read_ok, raw_angle, error_code, time_stamp, output ready);
endinterface

interface epp_out_if;
    logic                              valid;
    logic                              ready;
    logic [epp_pkg::STAMP_W-1:0]       stamp_out;
    logic                              position_valid;
    logic signed [epp_pkg::ANGLE_W-1:0] position;
    logic [epp_pkg::ANGLE_W-1:0]       electrical_phase;
    logic [epp_pkg::COUNT_W-1:0]       error_total;
    logic [epp_pkg::CODE_W-1:0]        first_error;
    logic [epp_pkg::CODE_W-1:0]        last_error;

    modport source (output valid, stamp_out, position_valid, position, electrical_phase,
                    error_total, first_error, last_error, input ready);
    modport sink   (input valid, stamp_out, position_valid, position, electrical_phase,
                    error_total, first_error, last_error, output ready);
endinterface

interface epp_cfg_if;
    logic                              valid;
    logic                              ready;
    epp_pkg::t_cfg_addr                addr;
    logic [epp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/encoder_position_and_phase_unit.sv -----
// Encoder position and electrical phase unit. Takes one encoder read result per
// cycle and returns one result per read, through the input register and then the
// result register; one read per clock is sustained as long as the result side
// takes a transfer every cycle. The single datapath pass between the two
// registers does scale, optional negate, offset add, phase-center subtract and
// one 16x7 multiply. Angles use 65536 units per turn; a successful read updates
// position and phase, a failed read keeps them, bumps the saturating error count,
// sets the last error code and sets the first error code while it is still zero.
// Configuration is taken every cycle and should only be written while idle.
`include "encoder_position_and_phase_unit_assert.svh"

module encoder_position_and_phase_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    epp_cfg_if.sink         i_cfg,
    epp_in_if.sink          i_in,
    epp_out_if.source       o_out
);

    // configuration
    logic                              r_reverse;
    logic [epp_pkg::ANGLE_W-1:0]       r_offset;
    logic [epp_pkg::ANGLE_W-1:0]       r_center;
    logic [epp_pkg::POLE_W-1:0]        r_poles;

    // input stage
    logic                              r_in_valid;
    logic                              r_in_ok;
    logic [epp_pkg::RAW_W-1:0]         r_in_raw;
    logic [epp_pkg::CODE_W-1:0]        r_in_code;
    logic [epp_pkg::STAMP_W-1:0]       r_in_stamp;

    // result stage and held state
    logic                              r_out_valid;
    logic                              r_out_ok;
    logic [epp_pkg::STAMP_W-1:0]       r_out_stamp;
    logic [epp_pkg::ANGLE_W-1:0]       r_pos;
    logic [epp_pkg::ANGLE_W-1:0]       r_phase;
    logic [epp_pkg::COUNT_W-1:0]       r_err_cnt;
    logic [epp_pkg::CODE_W-1:0]        r_first_err;
    logic [epp_pkg::CODE_W-1:0]        r_last_err;

    logic                              w_out_free;
    logic                              w_adv;
    logic [epp_pkg::ANGLE_W-1:0]       w_scaled;
    logic [epp_pkg::ANGLE_W-1:0]       w_dir;
    logic [epp_pkg::ANGLE_W-1:0]       w_diff;
    logic [epp_pkg::ANGLE_W-1:0]       n_pos;
    logic [epp_pkg::ANGLE_W-1:0]       n_phase;
    logic [epp_pkg::COUNT_W-1:0]       n_err_cnt;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse <= 1'b0;
            r_offset  <= '0;
            r_center  <= '0;
            r_poles   <= epp_pkg::POLE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                epp_pkg::CFG_REVERSE: r_reverse <= i_cfg.data[0];
                epp_pkg::CFG_OFFSET:  r_offset  <= i_cfg.data[epp_pkg::ANGLE_W-1:0];
                epp_pkg::CFG_CENTER:  r_center  <= i_cfg.data[epp_pkg::ANGLE_W-1:0];
                epp_pkg::CFG_POLES:   r_poles   <= i_cfg.data[epp_pkg::POLE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the result register frees up when it is empty or being taken
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_in.ready  = i_rst_n && (!r_in_valid || w_out_free);

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ok    <= i_in.read_ok;
            r_in_raw   <= i_in.raw_angle;
            r_in_code  <= i_in.error_code;
            r_in_stamp <= i_in.time_stamp;
        end
    end

    // 14-bit counts to 16-bit turn units; all math wraps modulo one turn
    assign w_scaled  = {r_in_raw, 2'b00};
    assign w_dir     = r_reverse ? ({epp_pkg::ANGLE_W{1'b0}} - w_scaled) : w_scaled;
    assign n_pos     = w_dir + r_offset;
    assign w_diff    = n_pos - r_center;
    assign n_phase   = w_diff * {{(epp_pkg::ANGLE_W-epp_pkg::POLE_W){1'b0}}, r_poles};
    assign n_err_cnt = (r_err_cnt == {epp_pkg::COUNT_W{1'b1}}) ? r_err_cnt
                                                                : r_err_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_err_cnt   <= '0;
            r_first_err <= '0;
            r_last_err  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                if (r_in_ok) begin
                    r_pos   <= n_pos;
                    r_phase <= n_phase;
                end else begin
                    r_err_cnt  <= n_err_cnt;
                    r_last_err <= r_in_code;
                    if (r_first_err == '0) begin
                        r_first_err <= r_in_code;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ok    <= r_in_ok;
            r_out_stamp <= r_in_stamp;
        end
    end

    // held state only changes when a new result loads, so it drives the port directly
    assign o_out.valid            = r_out_valid;
    assign o_out.stamp_out        = r_out_stamp;
    assign o_out.position_valid   = r_out_ok;
    assign o_out.position         = $signed(r_pos);
    assign o_out.electrical_phase = r_phase;
    assign o_out.error_total      = r_err_cnt;
    assign o_out.first_error      = r_first_err;
    assign o_out.last_error       = r_last_err;

    `EPP_ASSERT(a_in_transfer_fills, i_in.valid && i_in.ready |=> r_in_valid)
    `EPP_ASSERT(a_err_cnt_monotonic, $past(i_rst_n) |-> r_err_cnt >= $past(r_err_cnt))
    `EPP_ASSERT(a_first_err_sticky, $past(i_rst_n && r_first_err != '0) |-> $stable(r_first_err))
    `EPP_ASSERT(a_fail_holds_pos, $past(i_rst_n && w_adv && !r_in_ok) |-> $stable({r_pos, r_phase}))
    `EPP_ASSERT_ALWAYS(a_reset_empties, !$past(i_rst_n) && $past(1'b1) |-> !r_in_valid && !r_out_valid)

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [epp_pkg::STAMP_W-1:0] stamp;
        logic                        pos_valid;
        logic [epp_pkg::ANGLE_W-1:0] position;
        logic [epp_pkg::ANGLE_W-1:0] phase;
        logic [epp_pkg::COUNT_W-1:0] err_total;
        logic [epp_pkg::CODE_W-1:0]  first_code;
        logic [epp_pkg::CODE_W-1:0]  last_code;
    } t_update;

    logic i_clk = 1'b0;
    logic i_rst_n;

    epp_cfg_if cfg_if ();
    epp_in_if  in_if ();
    epp_out_if out_if ();

    encoder_position_and_phase_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor copy of registers and held state
    logic                        cfg_reverse;
    logic [epp_pkg::ANGLE_W-1:0] cfg_offset;
    logic [epp_pkg::ANGLE_W-1:0] cfg_center;
    logic [epp_pkg::POLE_W-1:0]  cfg_poles;
    logic [epp_pkg::ANGLE_W-1:0] held_pos;
    logic [epp_pkg::ANGLE_W-1:0] held_phase;
    logic [epp_pkg::COUNT_W-1:0] err_count;
    logic [epp_pkg::CODE_W-1:0]  first_code;
    logic [epp_pkg::CODE_W-1:0]  last_code;

    t_update expected_updates[$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    bit      in_steady   = 1'b0;
    bit      out_steady  = 1'b0;

    always #6 i_clk = ~i_clk;

    function automatic void reset_encoder_model();
        cfg_reverse = 1'b0;
        cfg_offset  = '0;
        cfg_center  = '0;
        cfg_poles   = epp_pkg::POLE_RESET;
        held_pos    = '0;
        held_phase  = '0;
        err_count   = '0;
        first_code  = '0;
        last_code   = '0;
    endfunction

    function automatic t_update predict_encoder_update(
            input logic                         ok,
            input logic [epp_pkg::RAW_W-1:0]    raw,
            input logic [epp_pkg::CODE_W-1:0]   code,
            input logic [epp_pkg::STAMP_W-1:0]  stamp);
        logic [epp_pkg::ANGLE_W-1:0] angle;
        t_update                     u;
        if (ok) begin
            angle = {raw, 2'b00};
            if (cfg_reverse) begin
                angle = -angle;
            end
            held_pos   = angle + cfg_offset;
            // only the low 16 bits matter, so sign extension drops out
            held_phase = (held_pos - cfg_center) * cfg_poles;
        end else begin
            if (err_count != '1) begin
                err_count = err_count + 1'b1;
            end
            last_code = code;
            if (first_code == '0) begin
                first_code = code;
            end
        end
        u.stamp      = stamp;
        u.pos_valid  = ok;
        u.position   = held_pos;
        u.phase      = held_phase;
        u.err_total  = err_count;
        u.first_code = first_code;
        u.last_code  = last_code;
        return u;
    endfunction

    task automatic report_mismatch(input string what, input t_update want,
                                   input t_update seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected stamp %h ok %b pos %0d phase %h errs %0d first %h last %h",
                     want.stamp, want.pos_valid, $signed(want.position), want.phase,
                     want.err_total, want.first_code, want.last_code);
            $display("  actual   stamp %h ok %b pos %0d phase %h errs %0d first %h last %h",
                     seen.stamp, seen.pos_valid, $signed(seen.position), seen.phase,
                     seen.err_total, seen.first_code, seen.last_code);
        end
    endtask

    // register writes
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.addr)
                epp_pkg::CFG_REVERSE: cfg_reverse = cfg_if.data[0];
                epp_pkg::CFG_OFFSET:  cfg_offset  = cfg_if.data;
                epp_pkg::CFG_CENTER:  cfg_center  = cfg_if.data;
                epp_pkg::CFG_POLES:   cfg_poles   = cfg_if.data[epp_pkg::POLE_W-1:0];
                default: ;
            endcase
        end
    end

    // encoder reads
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            expected_updates.push_back(predict_encoder_update(in_if.read_ok, in_if.raw_angle,
                                                              in_if.error_code,
                                                              in_if.time_stamp));
        end
    end

    always @(posedge i_clk) begin : check_updates
        t_update seen;
        t_update want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.stamp      = out_if.stamp_out;
            seen.pos_valid  = out_if.position_valid;
            seen.position   = out_if.position;
            seen.phase      = out_if.electrical_phase;
            seen.err_total  = out_if.error_total;
            seen.first_code = out_if.first_error;
            seen.last_code  = out_if.last_error;
            if (expected_updates.size() == 0) begin
                report_mismatch("update with no read pending", '0, seen);
            end else begin
                want = expected_updates.pop_front();
                if (seen !== want) begin
                    report_mismatch("update mismatch", want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial begin : update_sink
        int stall;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = out_steady ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // valid stays high across back-to-back reads; end_reads drops it
    task automatic send_read(input logic ok, input logic [epp_pkg::RAW_W-1:0] raw,
                             input logic [epp_pkg::CODE_W-1:0] code,
                             input logic [epp_pkg::STAMP_W-1:0] stamp);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.read_ok    <= ok;
        in_if.raw_angle  <= raw;
        in_if.error_code <= code;
        in_if.time_stamp <= stamp;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic end_reads();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_for_updates();
        end_reads();
        while (expected_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input epp_pkg::t_cfg_addr idx,
                             input logic [epp_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // unused upper data bits carry junk, the block must mask them
    task automatic write_config(input logic rev, input logic [epp_pkg::ANGLE_W-1:0] offset,
                                input logic [epp_pkg::ANGLE_W-1:0] center,
                                input logic [epp_pkg::POLE_W-1:0] poles);
        write_reg(epp_pkg::CFG_REVERSE, {15'($urandom), rev});
        write_reg(epp_pkg::CFG_OFFSET, offset);
        write_reg(epp_pkg::CFG_CENTER, center);
        write_reg(epp_pkg::CFG_POLES, {9'($urandom), poles});
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [epp_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [epp_pkg::RAW_W-1:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 14'd8192;
            default: return 14'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        // half turn with two poles lands on a whole cycle and folds to zero
        send_read(1'b1, 14'd0, 8'h00, 32'h0000_0000);
        send_read(1'b1, 14'h3FFF, 8'hFF, 32'hFFFF_FFFF);
        send_read(1'b1, 14'd8192, 8'h5A, $urandom);
        send_read(1'b1, 14'd4096, 8'hA5, $urandom);
        wait_for_updates();
    endtask

    task automatic test_error_codes();
        // code zero first: counted, but first code stays unset
        send_read(1'b0, pick_raw(), 8'd0, $urandom);
        send_read(1'b0, pick_raw(), 8'd1, $urandom);
        send_read(1'b0, pick_raw(), 8'd255, $urandom);
        send_read(1'b0, pick_raw(), 8'd0, $urandom);
        send_read(1'b1, 14'h1555, 8'h00, $urandom);
        send_read(1'b0, 14'h2AAA, 8'h5A, $urandom);
        wait_for_updates();
    endtask

    task automatic test_register_extremes();
        write_config(1'b1, 16'h8000, 16'h7FFF, 7'd64);
        send_read(1'b1, 14'd0, 8'($urandom), $urandom);
        send_read(1'b1, 14'h3FFF, 8'($urandom), $urandom);
        send_read(1'b1, 14'd8192, 8'($urandom), $urandom);
        wait_for_updates();
        write_config(1'b0, 16'h7FFF, 16'h8000, 7'd1);
        send_read(1'b1, 14'd0, 8'($urandom), $urandom);
        send_read(1'b1, 14'h3FFF, 8'($urandom), $urandom);
        wait_for_updates();
        // zero poles: phase is always zero
        write_config(1'b1, 16'h0000, 16'h0000, 7'd0);
        send_read(1'b1, 14'h0F0F, 8'($urandom), $urandom);
        send_read(1'b1, 14'h30F0, 8'($urandom), $urandom);
        wait_for_updates();
        // poles past the normal range wrap the product
        write_config(1'b0, 16'h1234, 16'hF00D, 7'd127);
        send_read(1'b1, 14'h2345, 8'($urandom), $urandom);
        send_read(1'b1, 14'h1ABC, 8'($urandom), $urandom);
        wait_for_updates();
    endtask

    task automatic test_random_reads();
        logic [epp_pkg::POLE_W-1:0] poles;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0: poles = 7'd0;
                1: poles = 7'($urandom_range(65, 127));
                2: poles = 7'd64;
                3: poles = 7'd1;
                default: poles = 7'($urandom_range(1, 64));
            endcase
            write_config(1'($urandom), pick_angle(), pick_angle(), poles);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    in_steady  = ($urandom_range(0, 3) == 0);
                    out_steady = ($urandom_range(0, 3) == 0);
                end
                send_read($urandom_range(0, 9) < 7, pick_raw(), 8'($urandom), $urandom);
            end
            wait_for_updates();
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;
    endtask

    initial begin
        in_if.valid      = 1'b0;
        in_if.read_ok    = 1'b0;
        in_if.raw_angle  = '0;
        in_if.error_code = '0;
        in_if.time_stamp = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.addr      = epp_pkg::CFG_REVERSE;
        cfg_if.data      = '0;
        i_rst_n          = 1'b0;
        reset_encoder_model();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_error_codes();
        test_register_extremes();
        test_random_reads();

        wait_for_updates();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_updates.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
